// ===== hdl/htp_pkg.sv =====
`default_nettype none
package htp_pkg;

  // Build defaults
  localparam int MaxNestDef = 16;
  localparam int LenBitsDef = 16;

  // Token kinds
  localparam logic [3:0] K_TYPE   = 4'd0;
  localparam logic [3:0] K_END    = 4'd1;
  localparam logic [3:0] K_BOOL   = 4'd2;
  localparam logic [3:0] K_POS    = 4'd3;
  localparam logic [3:0] K_NEG    = 4'd4;
  localparam logic [3:0] K_DBL    = 4'd5;
  localparam logic [3:0] K_STR    = 4'd6;
  localparam logic [3:0] K_BYTES  = 4'd7;
  localparam logic [3:0] K_PAY    = 4'd8;
  localparam logic [3:0] K_AOPEN  = 4'd9;
  localparam logic [3:0] K_ACLOSE = 4'd10;
  localparam logic [3:0] K_MOPEN  = 4'd11;
  localparam logic [3:0] K_MCLOSE = 4'd12;
  localparam logic [3:0] K_ERR    = 4'd13;

  // One result word
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/htp_if.sv =====
`default_nettype none
// Input byte channel
interface htp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       buffer_last;
  modport source (output valid, byte_in, buffer_last, input ready);
  modport sink (input valid, byte_in, buffer_last, output ready);
endinterface

// Token result channel
interface htp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [63:0] token_value;
  logic        last_of_run;
  modport source (output valid, token_kind, token_value, last_of_run, input ready);
  modport sink (input valid, token_kind, token_value, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hdl/hex_text_token_parser.sv =====
`default_nettype none
// Channel   Dir  Payload                                   Handshake
// in_chan   in   byte_in[7:0], buffer_last                 valid/ready
// out_chan  out  token_kind[3:0], token_value[63:0], last  valid/ready
//
// A byte is decoded in the cycle it is accepted and its zero, one or two
// tokens go into a four-word result queue; one byte per cycle is taken
// while the queue has room. The result side drains one word per cycle
// while out_chan.ready is high. in_chan.ready drops while fewer than two
// queue slots are free. Reset (rst_n low, synchronous) empties the queue
// and sets the parser to expect a type byte.
module hex_text_token_parser #(
  parameter int MAX_NEST = htp_pkg::MaxNestDef,
  parameter int LEN_BITS = htp_pkg::LenBitsDef
) (
  input  wire       clk,
  input  wire       rst_n,
  htp_in_if.sink    in_chan,
  htp_out_if.source out_chan
);

  localparam int DW = $clog2(MAX_NEST + 1);

  typedef enum logic [13:0] {
    PH_TYPE  = 14'h0001, PH_SEP   = 14'h0002, PH_ATOM  = 14'h0004,
    PH_NEG   = 14'h0008, PH_DIG   = 14'h0010, PH_EXPS  = 14'h0020,
    PH_EXPF  = 14'h0040, PH_EXPD  = 14'h0080, PH_I1    = 14'h0100,
    PH_I2    = 14'h0200, PH_N1    = 14'h0400, PH_N2    = 14'h0800,
    PH_PAY   = 14'h1000, PH_DROP  = 14'h2000
  } phase_t;

  localparam logic [7:0] CH_SP = 8'h20, CH_NL = 8'h0a, CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LB = 8'h5b, CH_RB = 8'h5d, CH_LC = 8'h7b, CH_RC = 8'h7d;
  localparam logic [7:0] CH_T = 8'h54, CH_F = 8'h46, CH_I = 8'h69, CH_N = 8'h6e;
  localparam logic [7:0] CH_A = 8'h61, CH_FL = 8'h66, CH_P = 8'h70;
  localparam logic [7:0] CH_COL = 8'h3a, CH_BAR = 8'h7c;

  // Parser state
  phase_t              phase_r, phase_nxt;
  logic [63:0]         sig_r, sig_nxt;
  logic [4:0]          ndig_r, ndig_nxt;
  logic [1:0]          fz_r, fz_nxt;
  logic [11:0]         emag_r, emag_nxt;
  logic                eneg_r, eneg_nxt;
  logic                vneg_r, vneg_nxt;
  logic [LEN_BITS-1:0] pay_r, pay_nxt;
  logic [MAX_NEST-1:0] nk_r, nk_nxt;
  logic [DW-1:0]       nd_r, nd_nxt;

  // Result queue
  htp_pkg::res_t q_r [4];
  logic [1:0]    wp_r, rp_r;
  logic [2:0]    cnt_r;

  logic [7:0] b;
  logic       blast, acc, pop;
  assign b     = in_chan.byte_in;
  assign blast = in_chan.buffer_last;
  assign in_chan.ready = (cnt_r <= 3'd2);
  assign acc = in_chan.valid && in_chan.ready;
  assign pop = out_chan.valid && out_chan.ready;

  // Hex digit decode
  logic       is_hex;
  logic [3:0] d;
  always_comb begin
    is_hex = 1'b1;
    d = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) d = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) d = 4'(b - 8'h57);
    else is_hex = 1'b0;
  end

  // Number finish: leading zeros come from the digit count
  logic [5:0]         lzc;
  logic signed [13:0] e_s, et, et2;
  logic [63:0]        frac, intval, dbl;
  logic [64:0]        rnd;
  logic [10:0]        expf;
  logic [51:0]        mant;
  logic               is_dbl;
  always_comb begin
    lzc  = 6'(7'(4 * (5'd16 - ndig_r)) + 7'(fz_r));
    e_s  = eneg_r ? -$signed({2'b00, emag_r}) : $signed({2'b00, emag_r});
    frac = (sig_r << lzc) << 1;
    rnd  = {1'b0, frac} + (frac[11] ? 65'h800 : 65'h0);
    et   = e_s + 14'sd63 - $signed({8'd0, lzc});
    et2  = et + $signed({13'd0, rnd[64]});
    if (et2 < -14'sd1022) begin
      expf = 11'd0; mant = 52'd0;
    end else if (et2 > 14'sd1023) begin
      expf = 11'h7ff; mant = 52'd0;
    end else begin
      expf = 11'(et2 + 14'sd1023); mant = rnd[63:12];
    end
    dbl    = {vneg_r, expf, mant};
    is_dbl = (e_s < 0) || (e_s > $signed({8'd0, lzc}));
    intval = sig_r << e_s[5:0];
  end

  // Per-byte decode
  htp_pkg::res_t r [2];
  logic [1:0]    rc;
  logic          fl, sep, fin, fin_exp, brk_open, brk_arr;
  logic [15:0]   emul;
  always_comb begin
    phase_nxt = phase_r; sig_nxt = sig_r; ndig_nxt = ndig_r; fz_nxt = fz_r;
    emag_nxt = emag_r; eneg_nxt = eneg_r; vneg_nxt = vneg_r; pay_nxt = pay_r;
    nk_nxt = nk_r; nd_nxt = nd_r;
    r[0] = '0; r[1] = '0; rc = 2'd0;
    fl = 1'b0; sep = 1'b0; fin = 1'b0; fin_exp = 1'b0;
    brk_open = (b == CH_LB) || (b == CH_LC);
    brk_arr  = (b == CH_LB) || (b == CH_RB);
    emul = {emag_r, 4'd0} + 16'(d);
    unique case (phase_r)
      PH_TYPE: begin
        if (b <= CH_SP) fl = 1'b1;
        else begin
          r[0] = '{htp_pkg::K_TYPE, 64'(b), 1'b0}; rc = 2'd1; phase_nxt = PH_SEP;
        end
      end
      PH_SEP: sep = 1'b1;
      PH_ATOM: begin
        vneg_nxt = 1'b0; eneg_nxt = 1'b0; emag_nxt = '0; sig_nxt = '0;
        if (b == CH_MINUS) begin vneg_nxt = 1'b1; phase_nxt = PH_NEG; end
        else if (b == CH_I) phase_nxt = PH_I1;
        else if (b == CH_N) phase_nxt = PH_N1;
        else if (b == CH_T || b == CH_F) begin
          r[0] = '{htp_pkg::K_BOOL, 64'(b == CH_T), 1'b0}; rc = 2'd1;
          phase_nxt = PH_SEP;
        end else if (b == CH_LB || b == CH_RB || b == CH_LC || b == CH_RC) begin
          // a close at depth zero passes through unchecked
          if (brk_open) begin
            if (32'(nd_r) >= MAX_NEST) fl = 1'b1;
            else begin
              nk_nxt = (nk_r << 1) | MAX_NEST'(brk_arr); nd_nxt = nd_r + 1'b1;
            end
          end else if (nd_r != '0) begin
            if (nk_r[0] != brk_arr) fl = 1'b1;
            else begin
              nk_nxt = nk_r >> 1; nd_nxt = nd_r - 1'b1;
            end
          end
          if (!fl) begin
            r[0].kind = (b == CH_LB) ? htp_pkg::K_AOPEN : (b == CH_RB) ? htp_pkg::K_ACLOSE :
                        (b == CH_LC) ? htp_pkg::K_MOPEN : htp_pkg::K_MCLOSE;
            rc = 2'd1; phase_nxt = PH_SEP;
          end
        end else if (!is_hex) fl = 1'b1;
        else begin
          sig_nxt = 64'(d); ndig_nxt = 5'd1; phase_nxt = PH_DIG;
          fz_nxt = d[3] ? 2'd0 : d[2] ? 2'd1 : d[1] ? 2'd2 : 2'd3;
        end
      end
      PH_NEG: begin
        if (b == CH_I) phase_nxt = PH_I1;
        else if (!is_hex) fl = 1'b1;
        else begin
          sig_nxt = 64'(d); ndig_nxt = 5'd1; phase_nxt = PH_DIG;
          fz_nxt = d[3] ? 2'd0 : d[2] ? 2'd1 : d[1] ? 2'd2 : 2'd3;
        end
      end
      PH_DIG: begin
        if (is_hex && sig_r != '0) begin
          if (sig_r[63:60] != 4'd0) fl = 1'b1;
          else begin sig_nxt = {sig_r[59:0], d}; ndig_nxt = ndig_r + 5'd1; end
        end else if (b == CH_P) begin
          if (!sig_r[0]) fl = 1'b1; else phase_nxt = PH_EXPS;
        end else if ((b == CH_COL || b == CH_BAR) && !vneg_r) begin
          if ((sig_r >> LEN_BITS) != '0) fl = 1'b1;
          else begin
            r[0] = '{(b == CH_COL) ? htp_pkg::K_STR : htp_pkg::K_BYTES, sig_r, 1'b0};
            rc = 2'd1;
            pay_nxt = sig_r[LEN_BITS-1:0];
            phase_nxt = (sig_r[LEN_BITS-1:0] != '0) ? PH_PAY : PH_SEP;
          end
        end else fin = 1'b1;
      end
      PH_EXPS: begin
        if (b == CH_MINUS) begin eneg_nxt = 1'b1; phase_nxt = PH_EXPF; end
        else if (!is_hex) fl = 1'b1;
        else begin emag_nxt = 12'(d); phase_nxt = PH_EXPD; end
      end
      PH_EXPF: begin
        if (!is_hex) fl = 1'b1;
        else begin emag_nxt = 12'(d); phase_nxt = PH_EXPD; end
      end
      PH_EXPD: begin
        if (is_hex && emag_r != '0) emag_nxt = (emul > 16'hfff) ? 12'hfff : emul[11:0];
        else begin fin = 1'b1; fin_exp = 1'b1; end
      end
      PH_I1: if (b == CH_N) phase_nxt = PH_I2; else fl = 1'b1;
      PH_I2: begin
        if (b == CH_FL) begin
          r[0] = '{htp_pkg::K_DBL, {vneg_r, 63'h7ff0000000000000}, 1'b0}; rc = 2'd1;
          phase_nxt = PH_SEP;
        end else fl = 1'b1;
      end
      PH_N1: if (b == CH_A) phase_nxt = PH_N2; else fl = 1'b1;
      PH_N2: begin
        if (b == CH_N) begin
          r[0] = '{htp_pkg::K_DBL, 64'h7ff8000000000000, 1'b0}; rc = 2'd1;
          phase_nxt = PH_SEP;
        end else fl = 1'b1;
      end
      PH_PAY: begin
        r[0] = '{htp_pkg::K_PAY, 64'(b), 1'b0}; rc = 2'd1;
        pay_nxt = pay_r - 1'b1;
        if (pay_r == LEN_BITS'(1)) phase_nxt = PH_SEP;
      end
      PH_DROP: ;
      default: fl = 1'b1;
    endcase

    // Number end
    if (fin) begin
      sep = 1'b1;
      priority if (!fin_exp && sig_r == '0) begin
        if (vneg_r) begin fl = 1'b1; sep = 1'b0; end
        else begin r[0] = '{htp_pkg::K_POS, 64'd0, 1'b0}; rc = 2'd1; end
      end else if (!fin_exp && sig_r[7:0] == 8'd0) begin
        fl = 1'b1; sep = 1'b0;
      end else if (fin_exp && is_dbl) begin
        r[0] = '{htp_pkg::K_DBL, dbl, 1'b0}; rc = 2'd1;
      end else begin
        r[0] = '{vneg_r ? htp_pkg::K_NEG : htp_pkg::K_POS, intval, 1'b0}; rc = 2'd1;
      end
    end

    // Separator
    if (sep) begin
      priority if (b == CH_NL) begin
        if (nd_r != '0) fl = 1'b1;
        else begin
          r[rc[0]] = '{htp_pkg::K_END, 64'd0, 1'b0}; rc = rc + 2'd1;
          phase_nxt = PH_TYPE;
        end
      end else if (b == CH_SP) phase_nxt = PH_ATOM;
      else fl = 1'b1;
    end

    // Error token
    if (fl) begin
      r[rc[0]] = '{htp_pkg::K_ERR, 64'd0, 1'b0}; rc = rc + 2'd1;
      phase_nxt = PH_DROP; nk_nxt = '0; nd_nxt = '0;
    end

    // Buffer end
    if (blast) begin
      if (phase_nxt != PH_TYPE && phase_nxt != PH_DROP && rc != 2'd2) begin
        r[rc[0]] = '{htp_pkg::K_ERR, 64'd0, 1'b0}; rc = rc + 2'd1;
      end
      phase_nxt = PH_TYPE; nk_nxt = '0; nd_nxt = '0;
    end
    if (rc == 2'd2) r[1].last = 1'b1;
    else if (rc == 2'd1) r[0].last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE; sig_r <= '0; ndig_r <= '0; fz_r <= '0; emag_r <= '0;
      eneg_r <= 1'b0; vneg_r <= 1'b0; pay_r <= '0; nk_r <= '0; nd_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt; sig_r <= sig_nxt; ndig_r <= ndig_nxt; fz_r <= fz_nxt;
      emag_r <= emag_nxt; eneg_r <= eneg_nxt; vneg_r <= vneg_nxt; pay_r <= pay_nxt;
      nk_r <= nk_nxt; nd_r <= nd_nxt;
    end
  end

  // Result queue
  logic [1:0] push_n;
  assign push_n = acc ? rc : 2'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push_n;
      rp_r  <= rp_r + 2'(pop);
      cnt_r <= cnt_r + 3'(push_n) - 3'(pop);
    end
  end
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wp_r] <= r[0];
    if (push_n == 2'd2) q_r[wp_r + 2'd1] <= r[1];
  end

  assign out_chan.valid       = (cnt_r != 3'd0);
  assign out_chan.token_kind  = q_r[rp_r].kind;
  assign out_chan.token_value = q_r[rp_r].value;
  assign out_chan.last_of_run = q_r[rp_r].last;

  // Checks
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overfilled");
  a_room: assert property (@(posedge clk) disable iff (!rst_n) acc |-> cnt_r <= 3'd2)
    else $error("byte taken without room for two words");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n) 32'(nd_r) <= MAX_NEST)
    else $error("nesting depth beyond limit");
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DROP |-> nd_r == '0)
    else $error("nesting left open while dropping");

endmodule
`default_nettype wire

// ===== verif/tb_hex_text_token_parser.sv =====
`timescale 1ns / 100ps
`default_nettype none

// Expected-token store and token predictor for the hex text parser
class token_scoreboard;
  typedef struct {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last;
  } token_t;

  localparam int PhType = 0, PhSep = 1, PhAtom = 2, PhNeg = 3, PhDigits = 4,
    PhExpStart = 5, PhExpFirst = 6, PhExpDigits = 7, PhI1 = 8, PhI2 = 9,
    PhN1 = 10, PhN2 = 11, PhPayload = 12, PhDrop = 13;

  token_t pending_tokens[$];
  token_t step_tokens[$];
  int phase;
  logic [63:0] sig;
  int exp_mag;
  bit exp_neg, val_neg;
  int pay_left;
  logic [15:0] nest_kinds;
  int nest_depth;
  int mismatches;
  int tokens_seen;

  function new();
    phase = PhType;
    sig = 0;
    exp_mag = 0;
    exp_neg = 0;
    val_neg = 0;
    pay_left = 0;
    nest_kinds = 0;
    nest_depth = 0;
    mismatches = 0;
    tokens_seen = 0;
  endfunction

  function void push_token(logic [3:0] k, logic [63:0] v);
    token_t t;
    if (step_tokens.size() < 2) begin
      t.kind = k;
      t.value = v;
      t.last = 0;
      step_tokens.push_back(t);
    end
  endfunction

  function void raise_error();
    push_token(htp_pkg::K_ERR, 0);
    phase = PhDrop;
    nest_kinds = 0;
    nest_depth = 0;
  endfunction

  function int digit_of(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    return -1;
  endfunction

  function int count_lz(logic [63:0] v);
    int n;
    n = 0;
    while (n < 64 && !v[63]) begin
      v = v << 1;
      n++;
    end
    return n;
  endfunction

  function logic [63:0] to_double(bit neg, logic [63:0] s, int e);
    int c;
    logic [63:0] frac, old;
    logic [10:0] expf;
    c = count_lz(s);
    frac = (c >= 63) ? 64'd0 : (s << (c + 1));
    e += 63 - c;
    if (frac[11]) begin
      old = frac;
      frac = frac + 64'h800;
      if (frac < old) e++;
    end
    if (e < -1022) begin
      frac = 0;
      expf = 0;
    end else if (e > 1023) begin
      frac = 0;
      expf = 11'h7FF;
    end else begin
      expf = 11'(1023 + e);
    end
    return {neg, expf, frac[63:12]};
  endfunction

  function void take_separator(logic [7:0] b);
    if (b == 8'h0a) begin
      if (nest_depth != 0) begin
        raise_error();
        return;
      end
      push_token(htp_pkg::K_END, 0);
      phase = PhType;
    end else if (b == " ") begin
      phase = PhAtom;
    end else begin
      raise_error();
    end
  endfunction

  function bit close_number(bit has_exp);
    int e, c;
    if (!has_exp) begin
      if (sig == 0) begin
        if (val_neg) begin
          raise_error();
          return 0;
        end
        push_token(htp_pkg::K_POS, 0);
        return 1;
      end
      if (sig[7:0] == 0) begin
        raise_error();
        return 0;
      end
      e = 0;
    end else begin
      e = exp_neg ? -exp_mag : exp_mag;
    end
    c = count_lz(sig);
    if (e < 0 || e > c) push_token(htp_pkg::K_DBL, to_double(val_neg, sig, e));
    else push_token(val_neg ? htp_pkg::K_NEG : htp_pkg::K_POS, sig << e);
    return 1;
  endfunction

  function void first_digit(logic [7:0] b);
    int d;
    d = digit_of(b);
    if (d < 0) begin
      raise_error();
      return;
    end
    sig = d;
    phase = PhDigits;
  endfunction

  function void take_bracket(logic [7:0] b);
    bit opening, arr;
    logic [3:0] k;
    opening = (b == "[" || b == "{");
    arr = (b == "[" || b == "]");
    k = (b == "[") ? htp_pkg::K_AOPEN : (b == "]") ? htp_pkg::K_ACLOSE :
        (b == "{") ? htp_pkg::K_MOPEN : htp_pkg::K_MCLOSE;
    if (opening) begin
      if (nest_depth >= 16) begin
        raise_error();
        return;
      end
      nest_kinds = {nest_kinds[14:0], arr};
      nest_depth++;
    end else if (nest_depth != 0) begin
      if (nest_kinds[0] != arr) begin
        raise_error();
        return;
      end
      nest_kinds = nest_kinds >> 1;
      nest_depth--;
    end
    push_token(k, 0);
    phase = PhSep;
  endfunction

  // Note one accepted input word and queue the tokens it should give
  function void note_byte(logic [7:0] b, bit blast);
    int d;
    step_tokens.delete();
    d = digit_of(b);
    case (phase)
      PhType: begin
        if (b <= 8'h20) raise_error();
        else begin
          push_token(htp_pkg::K_TYPE, b);
          phase = PhSep;
        end
      end
      PhSep: take_separator(b);
      PhAtom: begin
        val_neg = 0;
        exp_neg = 0;
        exp_mag = 0;
        sig = 0;
        if (b == "-") begin
          val_neg = 1;
          phase = PhNeg;
        end else if (b == "i") phase = PhI1;
        else if (b == "n") phase = PhN1;
        else if (b == "T" || b == "F") begin
          push_token(htp_pkg::K_BOOL, (b == "T"));
          phase = PhSep;
        end else if (b == "[" || b == "]" || b == "{" || b == "}") take_bracket(b);
        else first_digit(b);
      end
      PhNeg: begin
        if (b == "i") phase = PhI1;
        else first_digit(b);
      end
      PhDigits: begin
        if (d >= 0 && sig != 0) begin
          if (sig[63:60] != 0) raise_error();
          else sig = (sig << 4) | 64'(d);
        end else if (b == "p") begin
          if (!sig[0]) raise_error();
          else phase = PhExpStart;
        end else if ((b == ":" || b == "|") && !val_neg) begin
          if (sig[63:16] != 0) raise_error();
          else begin
            push_token(b == ":" ? htp_pkg::K_STR : htp_pkg::K_BYTES, sig);
            pay_left = int'(sig[15:0]);
            phase = (pay_left != 0) ? PhPayload : PhSep;
          end
        end else if (close_number(0)) begin
          take_separator(b);
        end
      end
      PhExpStart: begin
        if (b == "-") begin
          exp_neg = 1;
          phase = PhExpFirst;
        end else if (d < 0) raise_error();
        else begin
          exp_mag = d;
          phase = PhExpDigits;
        end
      end
      PhExpFirst: begin
        if (d < 0) raise_error();
        else begin
          exp_mag = d;
          phase = PhExpDigits;
        end
      end
      PhExpDigits: begin
        if (d >= 0 && exp_mag != 0) begin
          exp_mag = exp_mag * 16 + d;
          if (exp_mag > 'hFFF) exp_mag = 'hFFF;
        end else if (close_number(1)) begin
          take_separator(b);
        end
      end
      PhI1: if (b == "n") phase = PhI2; else raise_error();
      PhI2: begin
        if (b == "f") begin
          push_token(htp_pkg::K_DBL, {val_neg, 63'h7FF0000000000000});
          phase = PhSep;
        end else raise_error();
      end
      PhN1: if (b == "a") phase = PhN2; else raise_error();
      PhN2: begin
        if (b == "n") begin
          push_token(htp_pkg::K_DBL, 64'h7FF8000000000000);
          phase = PhSep;
        end else raise_error();
      end
      PhPayload: begin
        push_token(htp_pkg::K_PAY, b);
        if (pay_left != 0) pay_left--;
        if (pay_left == 0) phase = PhSep;
      end
      PhDrop: ;
      default: raise_error();
    endcase
    if (blast) begin
      if (phase != PhType && phase != PhDrop) raise_error();
      phase = PhType;
      nest_kinds = 0;
      nest_depth = 0;
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  // Compare one accepted result word with the oldest expected token
  function void check_token(logic [3:0] k, logic [63:0] v, logic l);
    token_t t;
    tokens_seen++;
    if (pending_tokens.size() == 0) begin
      $display("%0t: unexpected token kind=%0d value=%h last=%0b", $time, k, v, l);
      mismatches++;
      return;
    end
    t = pending_tokens.pop_front();
    if (k !== t.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, t.kind, k);
      mismatches++;
    end
    if (v !== t.value) begin
      $display("%0t: value expected %h actual %h", $time, t.value, v);
      mismatches++;
    end
    if (l !== t.last) begin
      $display("%0t: last expected %0b actual %0b", $time, t.last, l);
      mismatches++;
    end
  endfunction
endclass

module tb_hex_text_token_parser;

  logic clk = 0;
  logic rst_n = 0;
  htp_in_if in_chan ();
  htp_out_if out_chan ();

  hex_text_token_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan.sink),
    .out_chan(out_chan.source)
  );

  token_scoreboard sb;
  int idle_pct = 31;
  int bytes_sent = 0;
  byte unsigned msg_bytes[$];
  bit msg_lasts[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_chan.valid = 0;
    in_chan.byte_in = 0;
    in_chan.buffer_last = 0;
    out_chan.ready = 0;
  end

  // Result side: random stall, check every accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready)
        sb.check_token(out_chan.token_kind, out_chan.token_value, out_chan.last_of_run);
      out_chan.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Send one word, holding valid until accepted; valid drops only when idling
  task automatic send_byte(byte unsigned b, bit blast);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 0;
      @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.byte_in <= b;
    in_chan.buffer_last <= blast;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_byte(b, blast);
    bytes_sent++;
  endtask

  task automatic add_text(string s);
    foreach (s[i]) begin
      msg_bytes.push_back(s[i]);
      msg_lasts.push_back(0);
    end
  endtask

  task automatic flush_msg(bit mark_last);
    if (mark_last && msg_lasts.size() != 0) msg_lasts[msg_lasts.size() - 1] = 1;
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], msg_lasts[i]);
    msg_bytes.delete();
    msg_lasts.delete();
  endtask

  function automatic string rand_hex(int ndig);
    string s;
    s = "";
    for (int i = 0; i < ndig; i++)
      s = {s, $sformatf("%0h", (i == 0) ? $urandom_range(1, 15) : $urandom_range(15))};
    return s;
  endfunction

  // One random atom, mostly well formed
  function automatic string rand_atom();
    int n;
    string s;
    case ($urandom_range(13))
      0: return ($urandom_range(1)) ? "T" : "F";
      1: return ($urandom_range(1)) ? "[" : "{";
      2: return ($urandom_range(1)) ? "]" : "}";
      3: return ($urandom_range(1)) ? "inf" : "-inf";
      4: return "nan";
      5: return "0";
      6: begin
        s = rand_hex($urandom_range(1, 16));
        return ($urandom_range(1)) ? {"-", s} : s;
      end
      7: begin
        s = {rand_hex($urandom_range(1, 14)), $sformatf("%0h", 2 * $urandom_range(7) + 1)};
        return {s, "p", ($urandom_range(1)) ? "-" : "", rand_hex($urandom_range(1, 3))};
      end
      8, 9: begin
        n = $urandom_range(4);
        s = $sformatf("%0h%s", n, ($urandom_range(1)) ? ":" : "|");
        for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(255)))};
        if (n == 0) s = ($urandom_range(1)) ? "0:" : "0|";
        return s;
      end
      10: return $sformatf("%h", $urandom);
      11: return rand_hex(17);
      12: return "10000:";
      default: return string'(byte'($urandom_range(255)));
    endcase
  endfunction

  initial begin
    string deep;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed messages
    add_text("M T F 0 1 -1 ff01 100 -0 inf -inf nan\n"); flush_msg(1);
    add_text("M ffffffffffffff01 10000000000000001 1p10 3p-4 ffp1 1pfffff\n"); flush_msg(1);
    add_text("M 1fffffffffffffp-2 1p3ff -1p-3ff 00 01p0 2p1\n"); flush_msg(1);
    add_text("M [ { } ] ] { ]\n"); flush_msg(1);
    add_text("M 3:ab\n 0| ffff:\n"); flush_msg(1);
    deep = "M";
    for (int i = 0; i < 17; i++) deep = {deep, " ["};
    add_text(deep); flush_msg(1);
    add_text("M [\n"); flush_msg(1);
    add_text(" "); flush_msg(1);
    add_text("M i inx naX Q\n"); flush_msg(1);
    send_byte(8'hff, 0); send_byte(8'h00, 1);

    // Random messages; a long calm stretch in the middle
    while (bytes_sent < 1950) begin
      idle_pct = (bytes_sent > 800 && bytes_sent < 1100) ? 0 : 31;
      msg_bytes.push_back($urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(33, 126));
      msg_lasts.push_back(0);
      repeat ($urandom_range(1, 8)) begin
        add_text(($urandom_range(19) == 0) ? "\n" : " ");
        add_text(rand_atom());
      end
      if ($urandom_range(5) != 0) add_text("\n");
      flush_msg($urandom_range(9) != 0);
    end
    send_byte(8'h0a, 1);
    in_chan.valid <= 0;

    // Drain
    for (int w = 0; w < 100000 && sb.pending_tokens.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d input bytes and %0d result tokens", bytes_sent, sb.tokens_seen);
    if (sb.mismatches == 0 && sb.pending_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d tokens still expected", sb.mismatches,
               sb.pending_tokens.size());
      $display("status: fail");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule

`default_nettype wire

// ===== hex_text_token_parser.f =====
hdl/htp_pkg.sv
hdl/htp_if.sv
hdl/hex_text_token_parser.sv
verif/tb_hex_text_token_parser.sv
